>>> rtl/thc_pkg.sv
package thc_pkg;

  localparam int STAGES     = 13;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [2:0] {
    REG_TEMP_COEFF_1  = 3'd0,
    REG_TEMP_COEFF_2  = 3'd1,
    REG_TEMP_COEFF_3  = 3'd2,
    REG_HUM_COEFF_1   = 3'd3,
    REG_HUM_COEFF_2   = 3'd4,
    REG_HUM_COEFF_3   = 3'd5,
    REG_HUM_COEFF_4_5 = 3'd6,
    REG_HUM_COEFF_6   = 3'd7
  } reg_index_t;

  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam logic signed [31:0] FINE_OFFSET  = 32'sd76800;
  localparam logic signed [31:0] P_ROUND      = 32'sd16384;
  localparam logic signed [31:0] R_OFFSET     = 32'sd32768;
  localparam logic signed [31:0] Q_OFFSET     = 32'sd2097152;
  localparam logic signed [31:0] Q_ROUND      = 32'sd8192;
  localparam logic signed [31:0] HUM_MAX_ACC  = 32'sd419430400;
  localparam logic signed [31:0] CENTI_ROUND  = 32'sd128;

endpackage

>>> rtl/temp_humidity_compensation.sv
// Temperature and humidity compensation, integer fixed point.
// Words pass through the stages in order; a stage may hold more than one multiplier.
// Throughput: one word per cycle; each stage holds under back pressure and fills bubbles.
// Reset (rst, synchronous): clears all stage valid bits and all calibration registers to 0.
module temp_humidity_compensation (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [19:0]          raw_temperature,
  input  logic [15:0]          raw_humidity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   fine_temperature,
  output logic signed [23:0]   temperature_centi,
  output logic [16:0]          humidity_q10,
  input  logic                 cfg_write,
  input  thc_pkg::reg_index_t  cfg_index,
  input  thc_pkg::cfg_data_t   cfg_data
);
  import thc_pkg::*;

  logic [15:0] temp_coeff_1;
  logic [15:0] temp_coeff_2;
  logic [15:0] temp_coeff_3;
  logic [7:0]  hum_coeff_1;
  logic [15:0] hum_coeff_2;
  logic [7:0]  hum_coeff_3;
  logic [23:0] hum_coeff_4_5;
  logic [7:0]  hum_coeff_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeff_1  <= '0;
      temp_coeff_2  <= '0;
      temp_coeff_3  <= '0;
      hum_coeff_1   <= '0;
      hum_coeff_2   <= '0;
      hum_coeff_3   <= '0;
      hum_coeff_4_5 <= '0;
      hum_coeff_6   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_COEFF_1:  temp_coeff_1  <= cfg_data[15:0];
        REG_TEMP_COEFF_2:  temp_coeff_2  <= cfg_data[15:0];
        REG_TEMP_COEFF_3:  temp_coeff_3  <= cfg_data[15:0];
        REG_HUM_COEFF_1:   hum_coeff_1   <= cfg_data[7:0];
        REG_HUM_COEFF_2:   hum_coeff_2   <= cfg_data[15:0];
        REG_HUM_COEFF_3:   hum_coeff_3   <= cfg_data[7:0];
        REG_HUM_COEFF_4_5: hum_coeff_4_5 <= cfg_data;
        REG_HUM_COEFF_6:   hum_coeff_6   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] t1, t2, t3, h1, h2, h3, h5, h6;
  logic        [11:0] h4;

  assign t1 = {16'b0, temp_coeff_1};
  assign t2 = {{16{temp_coeff_2[15]}}, temp_coeff_2};
  assign t3 = {{16{temp_coeff_3[15]}}, temp_coeff_3};
  assign h1 = {24'b0, hum_coeff_1};
  assign h2 = {{16{hum_coeff_2[15]}}, hum_coeff_2};
  assign h3 = {24'b0, hum_coeff_3};
  assign h4 = hum_coeff_4_5[11:0];
  assign h5 = {{20{hum_coeff_4_5[23]}}, hum_coeff_4_5[23:12]};
  assign h6 = {{24{hum_coeff_6[7]}}, hum_coeff_6};

  // per-stage handshake
  logic [STAGES:1] v;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !v[STAGES] || out_ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int i = 2; i <= STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: temperature differences
  logic signed [31:0] s1_tdiff, s1_tdelta;
  logic [15:0]        s1_hraw;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_tdiff  <= {15'b0, raw_temperature[19:3]} - {15'b0, temp_coeff_1, 1'b0};
      s1_tdelta <= {16'b0, raw_temperature[19:4]} - t1;
      s1_hraw   <= raw_humidity;
    end
  end

  // stage 2
  logic signed [31:0] s2_tprod, s2_tsq;
  logic [15:0]        s2_hraw;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_tprod <= s1_tdiff * t2;
      s2_tsq   <= s1_tdelta * s1_tdelta;
      s2_hraw  <= s1_hraw;
    end
  end

  // stage 3
  logic signed [31:0] s3_ta, s3_tprod3;
  logic [15:0]        s3_hraw;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ta     <= s2_tprod >>> 11;
      s3_tprod3 <= (s2_tsq >>> 12) * t3;
      s3_hraw   <= s2_hraw;
    end
  end

  // stage 4: fine temperature
  logic signed [31:0] s4_fine;
  logic [15:0]        s4_hraw;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_fine <= s3_ta + (s3_tprod3 >>> 14);
      s4_hraw <= s3_hraw;
    end
  end

  // stage 5: centidegrees and humidity offset
  logic signed [31:0] cent_sum;
  logic signed [31:0] s5_fine, s5_x;
  logic signed [23:0] s5_cent;
  logic [15:0]        s5_hraw;

  assign cent_sum = (s4_fine <<< 2) + s4_fine + CENTI_ROUND;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_fine <= s4_fine;
      s5_cent <= cent_sum[31:8];
      s5_x    <= s4_fine - FINE_OFFSET;
      s5_hraw <= s4_hraw;
    end
  end

  // stage 6
  logic signed [31:0] s6_fine, s6_ph5, s6_qh6, s6_rh3;
  logic signed [23:0] s6_cent;
  logic [15:0]        s6_hraw;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_fine <= s5_fine;
      s6_cent <= s5_cent;
      s6_ph5  <= h5 * s5_x;
      s6_qh6  <= s5_x * h6;
      s6_rh3  <= s5_x * h3;
      s6_hraw <= s5_hraw;
    end
  end

  // stage 7
  logic signed [31:0] p_sum;
  logic signed [31:0] s7_fine, s7_p, s7_q, s7_r;
  logic signed [23:0] s7_cent;

  assign p_sum = $signed({2'b0, s6_hraw, 14'b0}) - $signed({h4, 20'b0}) - s6_ph5 + P_ROUND;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_fine <= s6_fine;
      s7_cent <= s6_cent;
      s7_p    <= p_sum >>> 15;
      s7_q    <= s6_qh6 >>> 10;
      s7_r    <= (s6_rh3 >>> 11) + R_OFFSET;
    end
  end

  // stage 8
  logic signed [31:0] s8_fine, s8_p, s8_qr;
  logic signed [23:0] s8_cent;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_fine <= s7_fine;
      s8_cent <= s7_cent;
      s8_p    <= s7_p;
      s8_qr   <= s7_q * s7_r;
    end
  end

  // stage 9
  logic signed [31:0] q_off;
  logic signed [31:0] s9_fine, s9_p, s9_qh2;
  logic signed [23:0] s9_cent;

  assign q_off = (s8_qr >>> 10) + Q_OFFSET;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_fine <= s8_fine;
      s9_cent <= s8_cent;
      s9_p    <= s8_p;
      s9_qh2  <= q_off * h2;
    end
  end

  // stage 10
  logic signed [31:0] q_scaled;
  logic signed [31:0] s10_fine, s10_r;
  logic signed [23:0] s10_cent;

  assign q_scaled = (s9_qh2 + Q_ROUND) >>> 14;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_fine <= s9_fine;
      s10_cent <= s9_cent;
      s10_r    <= s9_p * q_scaled;
    end
  end

  // stage 11
  logic signed [31:0] r_hi;
  logic signed [31:0] s11_fine, s11_r, s11_aa;
  logic signed [23:0] s11_cent;

  assign r_hi = s10_r >>> 15;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_fine <= s10_fine;
      s11_cent <= s10_cent;
      s11_r    <= s10_r;
      s11_aa   <= r_hi * r_hi;
    end
  end

  // stage 12
  logic signed [31:0] s12_fine, s12_r, s12_b;
  logic signed [23:0] s12_cent;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_fine <= s11_fine;
      s12_cent <= s11_cent;
      s12_r    <= s11_r;
      s12_b    <= (s11_aa >>> 7) * h1;
    end
  end

  // stage 13: clamp and output register
  logic signed [31:0] acc, acc_clamped;

  always_comb begin
    acc = s12_r - (s12_b >>> 4);
    if (acc[31]) begin
      acc_clamped = '0;
    end else if (acc > HUM_MAX_ACC) begin
      acc_clamped = HUM_MAX_ACC;
    end else begin
      acc_clamped = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      fine_temperature  <= s12_fine;
      temperature_centi <= s12_cent;
      humidity_q10      <= acc_clamped[28:12];
    end
  end

endmodule
